// ===== src/circle_collision_response_macros.svh =====
// Assertion macros used by the collision response top level.
`ifndef CIRCLE_COLLISION_RESPONSE_MACROS_SVH
`define CIRCLE_COLLISION_RESPONSE_MACROS_SVH
`ifndef NO_ASSERTIONS
`define CCR_ASSERT(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);
`define CCR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define CCR_ASSERT(lbl, expr, msg)
`define CCR_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ===== src/ccr_pkg.sv =====
// Shared constants and types of the collision response pipeline.
package ccr_pkg;
  localparam int CW = 16;
  localparam int FB = 8;
  localparam int RW = CW - 1;
  localparam int FW = 16;
  localparam int DW = CW + 1;
  localparam int SW = RW + 1;
  localparam int RTW = 2 * SW;
  localparam int QB = SW + 1;
  localparam int DIV_NW = DW + SW + 1;
  localparam int PW = QB + 1;
  localparam int SMW = PW + 1;
  localparam int PRW = SMW + FW + 1;
  localparam int DMIN_RAW = ((1 << FB) + 50) / 100;
  localparam int DMIN = (DMIN_RAW < 1) ? 1 : DMIN_RAW;

  localparam int S_NUM = 3 + SW;
  localparam int S_SUM = S_NUM + QB + 1;
  localparam int S_MUL = S_SUM + 1;
  localparam int S_OUT = S_MUL + 1;
  localparam int NS = S_OUT + 1;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_RADIUS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SECOND_RADIUS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FRICTION = 2'd2;

  localparam logic [RW-1:0] RADIUS_RESET = RW'(256);
  localparam logic [FW-1:0] FRICTION_RESET = FW'(64225);

  typedef struct packed {
    logic signed [CW-1:0] v1x;
    logic signed [CW-1:0] v1z;
    logic signed [CW-1:0] v2x;
    logic signed [CW-1:0] v2z;
    logic [DW-1:0] adx;
    logic [DW-1:0] adz;
    logic sx;
    logic sz;
    logic [SW-1:0] rsum;
    logic hit;
    logic upd;
    logic zero;
  } ccr_ctx_t;
endpackage

// ===== src/ccr_in_if.sv =====
// Channel carrying one disc pair word.
interface ccr_in_if;
  logic valid;
  logic ready;
  logic signed [ccr_pkg::CW-1:0] first_x;
  logic signed [ccr_pkg::CW-1:0] first_z;
  logic signed [ccr_pkg::CW-1:0] second_x;
  logic signed [ccr_pkg::CW-1:0] second_z;
  logic signed [ccr_pkg::CW-1:0] first_vx;
  logic signed [ccr_pkg::CW-1:0] first_vz;
  logic signed [ccr_pkg::CW-1:0] second_vx;
  logic signed [ccr_pkg::CW-1:0] second_vz;
  logic first_pocketed;
  logic second_pocketed;
  logic update_second;
  modport source (output valid, first_x, first_z, second_x, second_z, first_vx, first_vz,
                  second_vx, second_vz, first_pocketed, second_pocketed, update_second,
                  input ready);
  modport sink (input valid, first_x, first_z, second_x, second_z, first_vx, first_vz,
                second_vx, second_vz, first_pocketed, second_pocketed, update_second,
                output ready);
endinterface

// ===== src/ccr_out_if.sv =====
// Channel carrying one collision response word.
interface ccr_out_if;
  logic valid;
  logic ready;
  logic hit;
  logic signed [ccr_pkg::CW-1:0] first_vx_out;
  logic signed [ccr_pkg::CW-1:0] first_vz_out;
  logic signed [ccr_pkg::CW-1:0] second_vx_out;
  logic signed [ccr_pkg::CW-1:0] second_vz_out;
  logic second_valid;
  modport source (output valid, hit, first_vx_out, first_vz_out, second_vx_out,
                  second_vz_out, second_valid, input ready);
  modport sink (input valid, hit, first_vx_out, first_vz_out, second_vx_out,
                second_vz_out, second_valid, output ready);
endinterface

// ===== src/ccr_div.sv =====
// Pipelined restoring divider, one quotient bit per stage.
module ccr_div (
  input  logic clk,
  input  logic en,
  input  logic [ccr_pkg::DIV_NW-1:0] num,
  input  logic [ccr_pkg::SW-1:0] den,
  output logic [ccr_pkg::QB-1:0] quo
);
  import ccr_pkg::*;

  logic [DIV_NW-1:0] rem_r [QB];
  logic [SW-1:0] den_r [QB];
  logic [QB-1:0] q_r [QB];
  logic [DIV_NW-1:0] rem_nx [QB];
  logic [QB-1:0] q_nx [QB];
  logic [SW-1:0] den_in [QB];

  always_comb begin
    logic [DIV_NW-1:0] rem_in;
    logic [QB-1:0] q_in;
    logic [DIV_NW-1:0] shifted;
    for (int k = 0; k < QB; k++) begin
      if (k == 0) begin
        rem_in = num;
        q_in = '0;
        den_in[k] = den;
      end else begin
        rem_in = rem_r[k-1];
        q_in = q_r[k-1];
        den_in[k] = den_r[k-1];
      end
      shifted = DIV_NW'(den_in[k]) << (QB - 1 - k);
      if (rem_in >= shifted) begin
        rem_nx[k] = rem_in - shifted;
        q_nx[k] = q_in | (QB'(1) << (QB - 1 - k));
      end else begin
        rem_nx[k] = rem_in;
        q_nx[k] = q_in;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < QB; k++) begin
        rem_r[k] <= rem_nx[k];
        q_r[k] <= q_nx[k];
        den_r[k] <= den_in[k];
      end
    end
  end

  assign quo = q_r[QB-1];
endmodule

// ===== src/circle_collision_response.sv =====
// Top level of the pipelined disc collision response.
//
//   channel  dir  contents
//   pair     in   positions, velocities, pocketed flags, update_second
//   resp     out  hit, four new velocities, second_valid
//   cfg      in   radius and friction register writes
//
// Each word passes 40 register stages, among them the 16-stage square root and the 17-stage
// divider; a new word is accepted every cycle while the output word is not held untaken.
// Reset clears the stage valid bits and loads the register defaults.
// When the output word is not taken, the whole pipeline holds.
`include "circle_collision_response_macros.svh"
module circle_collision_response (
  input  logic clk,
  input  logic rst,
  ccr_in_if.sink pair,
  ccr_out_if.source resp,
  input  logic cfg_we,
  input  logic [ccr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ccr_pkg::FW-1:0] cfg_data
);
  import ccr_pkg::*;

  localparam logic signed [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};

  function automatic logic signed [CW-1:0] scale_sat(input logic signed [PRW-1:0] p);
    logic [PRW-1:0] a;
    logic [PRW-1:0] q;
    logic signed [PRW:0] r;
    a = p[PRW-1] ? PRW'(-p) : PRW'(p);
    q = (a + (PRW'(1) << (FW - 1))) >> FW;
    r = p[PRW-1] ? -$signed({1'b0, q}) : $signed({1'b0, q});
    if (r > (PRW+1)'(CMAX)) return CMAX;
    if (r < (PRW+1)'(CMIN)) return CMIN;
    return CW'(r);
  endfunction

  logic [RW-1:0] first_radius;
  logic [RW-1:0] second_radius;
  logic [FW-1:0] friction_factor;

  logic en;
  logic vld [NS];
  ccr_ctx_t ctx [NS];
  ccr_ctx_t ctx1_next, ctx2_next;
  logic signed [DW-1:0] dx0, dz0;
  logic [2*DW-1:0] sqx, sqz;
  logic [RTW-1:0] rr;
  logic [RTW-1:0] sq_n [SW+1];
  logic [RTW-1:0] sq_res [SW+1];
  logic [RTW-1:0] sq_n_next [SW];
  logic [RTW-1:0] sq_res_next [SW];
  logic [DIV_NW-1:0] numx, numz;
  logic [SW-1:0] den;
  logic [QB-1:0] qx, qz;
  logic signed [SMW-1:0] s1x, s1z, s2x, s2z;
  logic signed [PRW-1:0] p1x, p1z, p2x, p2z;
  logic o_hit, o_sv;
  logic signed [CW-1:0] o1x, o1z, o2x, o2z;

  logic signed [DW-1:0] dx_in, dz_in;
  logic [DW-1:0] adx1, adz1;
  logic [2*DW:0] d2;
  logic [SW-1:0] sq_root;
  logic [SW-1:0] reb;
  logic signed [PW-1:0] px, pz;

  assign en = !vld[NS-1] || resp.ready;
  assign pair.ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      first_radius <= RADIUS_RESET;
      second_radius <= RADIUS_RESET;
      friction_factor <= FRICTION_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FIRST_RADIUS: first_radius <= cfg_data[RW-1:0];
        CFG_SECOND_RADIUS: second_radius <= cfg_data[RW-1:0];
        CFG_FRICTION: friction_factor <= cfg_data;
        default: ;
      endcase
    end
  end

  assign dx_in = DW'(pair.first_x) - DW'(pair.second_x);
  assign dz_in = DW'(pair.first_z) - DW'(pair.second_z);
  assign adx1 = dx0[DW-1] ? DW'(-dx0) : DW'(dx0);
  assign adz1 = dz0[DW-1] ? DW'(-dz0) : DW'(dz0);
  assign d2 = {1'b0, sqx} + {1'b0, sqz};
  assign sq_root = sq_res[SW][SW-1:0];
  assign reb = ctx[S_NUM-1].rsum - sq_root;

  always_comb begin
    ctx1_next = ctx[0];
    ctx1_next.adx = adx1;
    ctx1_next.adz = adz1;
    ctx1_next.hit = ctx[0].hit && (adx1 <= DW'(ctx[0].rsum)) && (adz1 <= DW'(ctx[0].rsum));
    ctx2_next = ctx[1];
    ctx2_next.hit = ctx[1].hit && (d2 <= (2*DW+1)'(rr));
    ctx2_next.zero = (d2 == '0);
  end

  always_comb begin
    logic [RTW-1:0] bitv;
    logic [RTW:0] t;
    for (int k = 0; k < SW; k++) begin
      bitv = RTW'(1) << (2 * (SW - 1 - k));
      t = {1'b0, sq_res[k]} + {1'b0, bitv};
      if ({1'b0, sq_n[k]} >= t) begin
        sq_n_next[k] = sq_n[k] - t[RTW-1:0];
        sq_res_next[k] = (sq_res[k] >> 1) + bitv;
      end else begin
        sq_n_next[k] = sq_n[k];
        sq_res_next[k] = sq_res[k] >> 1;
      end
    end
  end

  always_comb begin
    if (ctx[S_SUM-1].zero) begin
      px = PW'($signed({2'b0, ctx[S_SUM-1].rsum})) - PW'(DMIN);
      pz = '0;
    end else begin
      px = ctx[S_SUM-1].sx ? -$signed({1'b0, qx}) : $signed({1'b0, qx});
      pz = ctx[S_SUM-1].sz ? -$signed({1'b0, qz}) : $signed({1'b0, qz});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NS; i++) vld[i] <= 1'b0;
    end else if (en) begin
      vld[0] <= pair.valid;
      for (int i = 1; i < NS; i++) vld[i] <= vld[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctx[1] <= ctx1_next;
      ctx[2] <= ctx2_next;
      for (int i = 3; i < NS; i++) ctx[i] <= ctx[i-1];
      ctx[0].v1x <= pair.first_vx;
      ctx[0].v1z <= pair.first_vz;
      ctx[0].v2x <= pair.second_vx;
      ctx[0].v2z <= pair.second_vz;
      ctx[0].adx <= '0;
      ctx[0].adz <= '0;
      ctx[0].sx <= dx_in[DW-1];
      ctx[0].sz <= dz_in[DW-1];
      ctx[0].rsum <= SW'(first_radius) + SW'(second_radius);
      ctx[0].hit <= !pair.first_pocketed && !pair.second_pocketed;
      ctx[0].upd <= pair.update_second;
      ctx[0].zero <= 1'b0;
      dx0 <= dx_in;
      dz0 <= dz_in;

      sqx <= adx1 * adx1;
      sqz <= adz1 * adz1;
      rr <= ctx[0].rsum * ctx[0].rsum;

      sq_n[0] <= d2[RTW-1:0];
      sq_res[0] <= '0;

      for (int k = 0; k < SW; k++) begin
        sq_n[k+1] <= sq_n_next[k];
        sq_res[k+1] <= sq_res_next[k];
      end

      numx <= DIV_NW'(ctx[S_NUM-1].adx) * DIV_NW'(reb) + DIV_NW'(sq_root >> 1);
      numz <= DIV_NW'(ctx[S_NUM-1].adz) * DIV_NW'(reb) + DIV_NW'(sq_root >> 1);
      den <= ctx[S_NUM-1].zero ? SW'(1) : sq_root;

      s1x <= SMW'(ctx[S_SUM-1].v1x) + SMW'(px);
      s1z <= SMW'(ctx[S_SUM-1].v1z) + SMW'(pz);
      s2x <= SMW'(ctx[S_SUM-1].v2x) - SMW'(px);
      s2z <= SMW'(ctx[S_SUM-1].v2z) - SMW'(pz);

      p1x <= s1x * $signed({1'b0, friction_factor});
      p1z <= s1z * $signed({1'b0, friction_factor});
      p2x <= s2x * $signed({1'b0, friction_factor});
      p2z <= s2z * $signed({1'b0, friction_factor});

      o_hit <= ctx[S_MUL].hit;
      o_sv <= ctx[S_MUL].hit && ctx[S_MUL].upd;
      o1x <= ctx[S_MUL].hit ? scale_sat(p1x) : ctx[S_MUL].v1x;
      o1z <= ctx[S_MUL].hit ? scale_sat(p1z) : ctx[S_MUL].v1z;
      o2x <= ctx[S_MUL].hit ? scale_sat(p2x) : ctx[S_MUL].v2x;
      o2z <= ctx[S_MUL].hit ? scale_sat(p2z) : ctx[S_MUL].v2z;
    end
  end

  ccr_div u_div_x (.clk(clk), .en(en), .num(numx), .den(den), .quo(qx));
  ccr_div u_div_z (.clk(clk), .en(en), .num(numz), .den(den), .quo(qz));

  assign resp.valid = vld[NS-1];
  assign resp.hit = o_hit;
  assign resp.second_valid = o_sv;
  assign resp.first_vx_out = o1x;
  assign resp.first_vz_out = o1z;
  assign resp.second_vx_out = o2x;
  assign resp.second_vz_out = o2z;

  `CCR_ASSERT(a_sv_needs_hit, !resp.valid || !resp.second_valid || resp.hit, "second_valid without hit")
  `CCR_ASSERT(a_miss_pass, !vld[NS-1] || o_hit || o1x == ctx[NS-1].v1x, "miss velocity changed")
  `CCR_ASSERT_NEXT(a_accept_enters, pair.valid && pair.ready, vld[0], "accepted word lost")
endmodule
